>>> sv/ptt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and defaults for the periodic timer table.
// ----------------------------------------------------------------------------
package ptt_pkg;

	// Default sizing of the table and of the id space.
	localparam int unsigned TIMER_SLOTS_DEF = 32;
	localparam int unsigned ID_LIMIT_DEF    = 65535;

	// Operation codes.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_ADV    = 2'd2;

	// Result kinds.
	localparam logic [2:0] K_ADDED   = 3'd0;
	localparam logic [2:0] K_FULL    = 3'd1;
	localparam logic [2:0] K_REMOVED = 3'd2;
	localparam logic [2:0] K_ABSENT  = 3'd3;
	localparam logic [2:0] K_FIRED   = 3'd4;
	localparam logic [2:0] K_DONE    = 3'd5;

	// Request and response transactions.
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] interval;
		logic [15:0] remove_id;
		logic [15:0] advance_ms;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] tmr_id;
		logic [16:0] fire_count;
		logic        last;
	} rsp_t;

	// One table entry.
	typedef struct packed {
		logic [15:0] id;
		logic [15:0] interval;
		logic [15:0] elapsed;
	} slot_t;

	// Source of a table write.
	typedef enum logic [1:0] {
		WR_ADD,
		WR_SHIFT,
		WR_ADV
	} wr_sel_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_RD,
		S_ADD_CMP,
		S_ADD_WR,
		S_RM_RD,
		S_RM_CMP,
		S_SH_RD,
		S_SH_WR,
		S_ADV_RD,
		S_ADV_LD,
		S_ADV_DIV,
		S_ADV_WB,
		S_ADV_FIRE,
		S_FINAL
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        latch_in;
		logic        take_id;
		logic        tries_clr;
		logic        clr_idx;
		logic        inc_idx;
		logic        rd_en;
		logic        rd_next;
		logic        wr_en;
		wr_sel_t     wr_sel;
		logic        cnt_inc;
		logic        cnt_dec;
		logic        div_start;
		logic        emit;
		logic [2:0]  emit_kind;
		logic        emit_last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] op;
		logic       is_full;
		logic       at_end;
		logic       shift_end;
		logic       cand_match;
		logic       rid_match;
		logic       tries_last;
		logic       ms_zero;
		logic       div_done;
		logic       quot_nz;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

>>> sv/ptt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_ctrl
// Controller state machine that sequences add, remove and advance operations.
// ----------------------------------------------------------------------------
module ptt_ctrl
	import ptt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	output logic       req_ready,
	input  wire stat_t st,
	output cmd_t       cmd
);

	state_t     state_q, state_d;
	logic [2:0] kind_q, kind_d;

	// State and pending final kind.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= K_DONE;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		cmd       = '0;
		cmd.wr_sel = WR_ADD;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.op)
					OP_ADD: begin
						if (st.is_full) begin
							kind_d  = K_FULL;
							state_d = S_FINAL;
						end else begin
							cmd.take_id   = 1'b1;
							cmd.tries_clr = 1'b1;
							cmd.clr_idx   = 1'b1;
							state_d       = S_ADD_RD;
						end
					end
					OP_REMOVE: begin
						cmd.clr_idx = 1'b1;
						state_d     = S_RM_RD;
					end
					OP_ADV: begin
						if (st.ms_zero) begin
							kind_d  = K_DONE;
							state_d = S_FINAL;
						end else begin
							cmd.clr_idx = 1'b1;
							state_d     = S_ADV_RD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD_RD: begin
				if (st.at_end) begin
					state_d = S_ADD_WR;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_ADD_CMP;
				end
			end
			S_ADD_CMP: begin
				if (st.cand_match) begin
					// Candidate in use: draw the next id and rescan.
					cmd.take_id = 1'b1;
					cmd.clr_idx = 1'b1;
					if (st.tries_last) begin
						kind_d  = K_FULL;
						state_d = S_FINAL;
					end else begin
						state_d = S_ADD_RD;
					end
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = S_ADD_RD;
				end
			end
			S_ADD_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_ADD;
				cmd.cnt_inc = 1'b1;
				kind_d      = K_ADDED;
				state_d     = S_FINAL;
			end
			S_RM_RD: begin
				if (st.at_end) begin
					kind_d  = K_ABSENT;
					state_d = S_FINAL;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_RM_CMP;
				end
			end
			S_RM_CMP: begin
				if (st.rid_match) begin
					state_d = S_SH_RD;
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = S_RM_RD;
				end
			end
			S_SH_RD: begin
				if (st.shift_end) begin
					cmd.cnt_dec = 1'b1;
					kind_d      = K_REMOVED;
					state_d     = S_FINAL;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
					state_d     = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.inc_idx = 1'b1;
				state_d     = S_SH_RD;
			end
			S_ADV_RD: begin
				if (st.at_end) begin
					kind_d  = K_DONE;
					state_d = S_FINAL;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_ADV_LD;
				end
			end
			S_ADV_LD: begin
				cmd.div_start = 1'b1;
				state_d       = S_ADV_DIV;
			end
			S_ADV_DIV: begin
				if (st.div_done) begin
					state_d = S_ADV_WB;
				end
			end
			S_ADV_WB: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_ADV;
				if (st.quot_nz) begin
					state_d = S_ADV_FIRE;
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = S_ADV_RD;
				end
			end
			S_ADV_FIRE: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = K_FIRED;
					cmd.inc_idx   = 1'b1;
					state_d       = S_ADV_RD;
				end
			end
			S_FINAL: begin
				if (st.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = kind_q;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/ptt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_dp
// Datapath: timer table memory, id allocator, serial divider, response register.
// ----------------------------------------------------------------------------
module ptt_dp
	import ptt_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF,
	parameter int unsigned ID_LIMIT    = ID_LIMIT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire req_t req,
	input  wire logic rsp_ready,
	output logic      rsp_valid,
	output rsp_t      rsp,
	input  wire cmd_t cmd,
	output stat_t     st
);

	localparam int unsigned IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
	localparam logic [CW:0] SLOTS_C = (CW + 1)'(TIMER_SLOTS);
	localparam logic [15:0] LIMIT_C = 16'(ID_LIMIT);

	slot_t       slot_mem [TIMER_SLOTS];
	slot_t       rd_q;
	req_t        req_q;
	logic [CW-1:0] idx_q, count_q, tries_q;
	logic [15:0] next_id_q, cand_q;
	logic [15:0] per_q;
	logic [16:0] rem_q, quot_q;
	logic [4:0]  div_cnt_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	logic [CW-1:0] idx_inc;
	logic [IW-1:0] rd_addr, wr_addr;
	slot_t         wr_data;
	logic [15:0]   id_pick;
	logic [16:0]   shl, e_sum;
	logic          ge;

	assign idx_inc = idx_q + CW'(1);
	assign id_pick = (next_id_q >= LIMIT_C) ? 16'd1 : next_id_q;

	// Held request.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			req_q <= req;
		end
	end

	// Index, count, tries and id allocation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			count_q   <= '0;
			tries_q   <= '0;
			next_id_q <= 16'd1;
			cand_q    <= '0;
		end else begin
			if (cmd.clr_idx) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_inc;
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.tries_clr) begin
				tries_q <= '0;
			end else if (cmd.take_id) begin
				tries_q <= tries_q + CW'(1);
			end
			if (cmd.take_id) begin
				cand_q    <= id_pick;
				next_id_q <= id_pick + 16'd1;
			end
		end
	end

	// Table memory with registered read.
	assign rd_addr = cmd.rd_next ? idx_inc[IW-1:0] : idx_q[IW-1:0];

	always_comb begin
		wr_addr = idx_q[IW-1:0];
		wr_data = rd_q;
		unique case (cmd.wr_sel)
			WR_ADD: begin
				wr_addr = count_q[IW-1:0];
				wr_data = '{id: cand_q,
					interval: (req_q.interval == 16'd0) ? 16'd1 : req_q.interval,
					elapsed: 16'd0};
			end
			WR_SHIFT: wr_data = rd_q;
			WR_ADV:   wr_data = '{id: rd_q.id, interval: rd_q.interval,
				elapsed: rem_q[15:0]};
			default:  wr_data = rd_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= slot_mem[rd_addr];
		end
	end

	// Restoring divider, one quotient bit per cycle.
	assign e_sum = {1'b0, rd_q.elapsed} + {1'b0, req_q.advance_ms};
	assign shl   = {rem_q[15:0], quot_q[16]};
	assign ge    = shl >= {1'b0, per_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= 5'd17;
		end else if (div_cnt_q != 5'd0) begin
			div_cnt_q <= div_cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			per_q  <= (rd_q.interval == 16'd0) ? 16'd1 : rd_q.interval;
			rem_q  <= '0;
			quot_q <= e_sum;
		end else if (div_cnt_q != 5'd0) begin
			rem_q  <= ge ? (shl - {1'b0, per_q}) : shl;
			quot_q <= {quot_q[15:0], ge};
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.kind       <= cmd.emit_kind;
			rsp_q.last       <= cmd.emit_last;
			rsp_q.fire_count <= (cmd.emit_kind == K_FIRED) ? quot_q : 17'd0;
			priority if (cmd.emit_kind == K_ADDED) begin
				rsp_q.tmr_id <= cand_q;
			end else if (cmd.emit_kind == K_REMOVED || cmd.emit_kind == K_ABSENT) begin
				rsp_q.tmr_id <= req_q.remove_id;
			end else if (cmd.emit_kind == K_FIRED) begin
				rsp_q.tmr_id <= rd_q.id;
			end else begin
				rsp_q.tmr_id <= 16'd0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status to the controller.
	always_comb begin
		st.op         = req_q.op;
		st.is_full    = {1'b0, count_q} >= SLOTS_C;
		st.at_end     = idx_q == count_q;
		st.shift_end  = idx_inc == count_q;
		st.cand_match = rd_q.id == cand_q;
		st.rid_match  = rd_q.id == req_q.remove_id;
		st.tries_last = {1'b0, tries_q} + (CW + 1)'(1) == SLOTS_C;
		st.ms_zero    = req_q.advance_ms == 16'd0;
		st.div_done   = div_cnt_q == 5'd0;
		st.quot_nz    = quot_q != 17'd0;
		st.out_free   = !rsp_valid_q || rsp_ready;
	end

endmodule
`default_nettype wire

>>> sv/periodic_timer_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_table_core
// Table of periodic timers with add, remove and advance operations.
// ----------------------------------------------------------------------------
// Usage: a request transaction (req_valid/req_ready, payload req) carries an
// add, remove or advance operation. Results leave on the response channel
// (rsp_valid/rsp_ready, payload rsp); the final result of a request has last
// set. Add and remove give one result; advance gives one fired result per due
// timer in table order, then a done result. Op code 3 is dropped silently.
// One request is processed at a time; req_ready is high only while idle.
// Remove walks the table entry by entry, then shifts each later entry down
// one slot; add scans the whole table for every candidate id; advance reads
// each timer and runs the 17-step serial divider that forms the expiration
// count and remainder. The table memory has one read and one write port.
// Each result passes through the output register.
// Reset empties the table and restarts ids at 1. When the receiver stalls, the
// held response waits in its register and the controller pauses before its
// next result, so no result is lost.
// ----------------------------------------------------------------------------
module periodic_timer_table_core
	import ptt_pkg::*;
#(
	parameter int unsigned TIMER_SLOTS = TIMER_SLOTS_DEF,
	parameter int unsigned ID_LIMIT    = ID_LIMIT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	cmd_t  cmd;
	stat_t st;

	// Sequencing.
	ptt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Storage and arithmetic.
	ptt_dp #(
		.TIMER_SLOTS (TIMER_SLOTS),
		.ID_LIMIT    (ID_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
`default_nettype wire

>>> sv/ptt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks of the timer table, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker
	import ptt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);

	// A stalled response transaction stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// One request at a time: after an accepted request the block is busy.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// Only fired results may be followed by more results.
	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.kind == K_FIRED)
		else $error("non-final result is not a fired result");

	// Fired results carry a nonzero count; others carry none.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.kind == K_FIRED) == (rsp.fire_count != 17'd0)))
		else $error("fire count inconsistent with kind");

endmodule

bind periodic_timer_table_core ptt_checker u_ptt_checker (.*);
`default_nettype wire
